FILE: src/raft_election_state_machine_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef RAFT_ELECTION_STATE_MACHINE_TOP_DEFINES_SVH
`define RAFT_ELECTION_STATE_MACHINE_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define RAFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RAFT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/raft_pkg.sv
`timescale 1ns / 1ps

package raft_pkg;

  // Default cluster size bound (width of the voter bitmap)
  localparam int MaxNodesDef = 16;

  localparam int TermW = 64;
  localparam int IdW   = 4;
  localparam int CntW  = 5;

  // Incoming event codes
  typedef enum logic [2:0] {
    CMD_TIMEOUT  = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_VOTE_RSP = 3'd2,
    CMD_REQ_VOTE = 3'd3,
    CMD_APPEND   = 3'd4
  } cmd_e;

  // Outgoing message kinds
  typedef enum logic [2:0] {
    KIND_NONE         = 3'd0,
    KIND_BCAST_VOTE   = 3'd1,
    KIND_BCAST_HB     = 3'd2,
    KIND_VOTE_REPLY   = 3'd3,
    KIND_APPEND_REPLY = 3'd4
  } kind_e;

  // Timer requests
  typedef enum logic [1:0] {
    TMR_NONE      = 2'd0,
    TMR_RESTART   = 2'd1,
    TMR_ELECTION  = 2'd2,
    TMR_HEARTBEAT = 2'd3
  } timer_e;

  // Node roles
  typedef enum logic [1:0] {
    ROLE_FOLLOWER  = 2'd0,
    ROLE_CANDIDATE = 2'd1,
    ROLE_LEADER    = 2'd2
  } role_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_NODE_ID   = 2'd0,
    REG_NUM_PEERS = 2'd1,
    REG_LAST_IDX  = 2'd2,
    REG_LAST_TERM = 2'd3
  } reg_e;

endpackage

FILE: src/raft_election_state_machine_top.sv
`timescale 1ns / 1ps
// Raft leader-election core for one node.
// Input channel (in_valid_i / in_stall_o): one event per item, cmd_i selects
// election timeout, heartbeat tick, vote response, RequestVote or AppendEntries.
// Output channel (out_valid_o / out_stall_i): exactly one result per event:
// message kind and contents, timer request, role and recorded leader after it.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (node id, peer count, last log index, last log term); write only when idle.
// An accepted event is held in the input register; the combinational
// state update then loads the result register, which offers the result.
// One event is taken every cycle while the receiver does not stall: the
// state registers load with the result, and the next event reads them.
// When the receiver stalls, the result holds and one more event can still be
// taken into the input register; after that in_stall_o rises.
// Reset clears term, role, vote, leader, vote count, voter bitmap, the
// configuration registers and both valid flags.
module raft_election_state_machine_top
  import raft_pkg::*;
#(
  parameter int MAX_NODES = MaxNodesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [TermW-1:0] cfg_wdata_i,
  // events
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       cmd_i,
  input  logic [TermW-1:0] msg_term_i,
  input  logic [IdW-1:0]   sender_id_i,
  input  logic             vote_granted_i,
  input  logic [TermW-1:0] cand_last_index_i,
  input  logic [TermW-1:0] cand_last_term_i,
  // results
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       out_kind_o,
  output logic [TermW-1:0] out_term_o,
  output logic             out_granted_o,
  output logic [TermW-1:0] out_index_o,
  output logic [TermW-1:0] out_log_term_o,
  output logic [IdW-1:0]   out_sender_o,
  output logic [1:0]       timer_action_o,
  output logic [1:0]       role_now_o,
  output logic             leader_known_o,
  output logic [IdW-1:0]   leader_now_o
);

  localparam logic [MAX_NODES-1:0] OneBit = MAX_NODES'(1);

  // configuration registers
  logic [IdW-1:0]   node_id_q;
  logic [IdW-1:0]   num_peers_q;
  logic [TermW-1:0] last_idx_q;
  logic [TermW-1:0] last_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q   <= '0;
      num_peers_q <= '0;
      last_idx_q  <= '0;
      last_term_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_NODE_ID:   node_id_q   <= cfg_wdata_i[IdW-1:0];
        REG_NUM_PEERS: num_peers_q <= cfg_wdata_i[IdW-1:0];
        REG_LAST_IDX:  last_idx_q  <= cfg_wdata_i;
        REG_LAST_TERM: last_term_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake: input stage advances when the result register is free
  logic in_valid_q, out_valid_q, advance, in_take;
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  logic [2:0]       cmd_q;
  logic [TermW-1:0] term_in_q;
  logic [IdW-1:0]   sender_q;
  logic             granted_in_q;
  logic [TermW-1:0] cidx_q;
  logic [TermW-1:0] cterm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q        <= cmd_i;
      term_in_q    <= msg_term_i;
      sender_q     <= sender_id_i;
      granted_in_q <= vote_granted_i;
      cidx_q       <= cand_last_index_i;
      cterm_q      <= cand_last_term_i;
    end
  end

  // election state
  logic [TermW-1:0]     term_q, term_d;
  role_e                role_q, role_d;
  logic                 voted_q, voted_d;
  logic [IdW-1:0]       voted_for_q, voted_for_d;
  logic                 lead_vld_q, lead_vld_d;
  logic [IdW-1:0]       lead_idx_q, lead_idx_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [MAX_NODES-1:0] mask_q, mask_d;

  // result values
  kind_e            kind_d;
  timer_e           timer_d;
  logic [TermW-1:0] o_term_d, o_idx_d, o_lt_d;
  logic             o_gr_d;

  // shared compares
  logic             term_gt, term_eq, log_ok;
  logic [MAX_NODES-1:0] sender_bit, self_bit;
  logic [CntW-1:0]  half, cnt_inc;

  assign term_gt    = term_in_q > term_q;
  assign term_eq    = term_in_q == term_q;
  assign log_ok     = (cterm_q > last_term_q) ||
                      ((cterm_q == last_term_q) && (cidx_q >= last_idx_q));
  assign sender_bit = OneBit << sender_q;
  assign self_bit   = OneBit << node_id_q;
  assign half       = (CntW'(num_peers_q) + CntW'(1)) >> 1;
  assign cnt_inc    = cnt_q + CntW'(1);

  // event handling
  always_comb begin
    logic grant;
    logic was_other;
    term_d      = term_q;
    role_d      = role_q;
    voted_d     = voted_q;
    voted_for_d = voted_for_q;
    lead_vld_d  = lead_vld_q;
    lead_idx_d  = lead_idx_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    kind_d      = KIND_NONE;
    timer_d     = TMR_NONE;
    o_term_d    = '0;
    o_idx_d     = '0;
    o_lt_d      = '0;
    o_gr_d      = 1'b0;
    grant       = 1'b0;
    was_other   = role_q != ROLE_FOLLOWER;

    case (cmd_q)
      CMD_TIMEOUT: begin
        if (role_q != ROLE_LEADER) begin
          term_d      = term_q + TermW'(1);
          role_d      = ROLE_CANDIDATE;
          voted_d     = 1'b1;
          voted_for_d = node_id_q;
          cnt_d       = CntW'(1);
          mask_d      = self_bit;
          lead_vld_d  = 1'b0;
          lead_idx_d  = '0;
          if (num_peers_q == '0) begin
            role_d     = ROLE_LEADER;
            lead_vld_d = 1'b1;
            lead_idx_d = node_id_q;
            timer_d    = TMR_HEARTBEAT;
            kind_d     = KIND_BCAST_HB;
          end else begin
            timer_d = TMR_RESTART;
            kind_d  = KIND_BCAST_VOTE;
          end
          o_term_d = term_d;
          o_idx_d  = last_idx_q;
          o_lt_d   = last_term_q;
        end
      end
      CMD_TICK: begin
        if (role_q == ROLE_LEADER) begin
          kind_d   = KIND_BCAST_HB;
          o_term_d = term_q;
          o_idx_d  = last_idx_q;
          o_lt_d   = last_term_q;
        end
      end
      CMD_VOTE_RSP: begin
        if (term_gt) begin
          // newer term seen: fall back to follower
          term_d      = term_in_q;
          role_d      = ROLE_FOLLOWER;
          voted_d     = 1'b0;
          voted_for_d = '0;
          lead_vld_d  = 1'b0;
          lead_idx_d  = '0;
          cnt_d       = '0;
          mask_d      = '0;
          timer_d     = TMR_ELECTION;
        end else if (term_eq && role_q == ROLE_CANDIDATE && granted_in_q &&
                     sender_bit != '0 && (mask_q & sender_bit) == '0) begin
          mask_d = mask_q | sender_bit;
          cnt_d  = cnt_inc;
          if (cnt_inc > half) begin
            role_d     = ROLE_LEADER;
            lead_vld_d = 1'b1;
            lead_idx_d = node_id_q;
            timer_d    = TMR_HEARTBEAT;
            kind_d     = KIND_BCAST_HB;
            o_term_d   = term_q;
            o_idx_d    = last_idx_q;
            o_lt_d     = last_term_q;
          end
        end
      end
      CMD_REQ_VOTE: begin
        kind_d = KIND_VOTE_REPLY;
        if (term_gt || term_eq) begin
          if (term_gt) begin
            term_d      = term_in_q;
            role_d      = ROLE_FOLLOWER;
            voted_d     = 1'b0;
            voted_for_d = '0;
            lead_vld_d  = 1'b0;
            lead_idx_d  = '0;
            cnt_d       = '0;
            mask_d      = '0;
          end
          grant = log_ok && !(voted_d && voted_for_d != sender_q);
          if (grant) begin
            voted_d     = 1'b1;
            voted_for_d = sender_q;
          end
          timer_d = term_gt ? TMR_ELECTION : (grant ? TMR_RESTART : TMR_NONE);
        end
        o_term_d = term_d;
        o_gr_d   = grant;
      end
      CMD_APPEND: begin
        kind_d = KIND_APPEND_REPLY;
        if (term_gt || term_eq) begin
          if (term_gt) begin
            term_d      = term_in_q;
            role_d      = ROLE_FOLLOWER;
            voted_d     = 1'b0;
            voted_for_d = '0;
            lead_vld_d  = 1'b0;
            lead_idx_d  = '0;
            cnt_d       = '0;
            mask_d      = '0;
          end else if (was_other) begin
            role_d = ROLE_FOLLOWER;
            cnt_d  = '0;
            mask_d = '0;
          end
          // first leader heard in this term is adopted
          if (!lead_vld_d) begin
            lead_vld_d = 1'b1;
            lead_idx_d = sender_q;
            grant      = 1'b1;
          end else begin
            grant = lead_idx_d == sender_q;
          end
          timer_d = was_other ? TMR_ELECTION : (grant ? TMR_RESTART : TMR_NONE);
        end
        o_term_d = term_d;
        o_gr_d   = grant;
        o_idx_d  = last_idx_q;
      end
      default: ;
    endcase
  end

  // state and result registers
  logic             fire;
  assign fire = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q      <= '0;
      role_q      <= ROLE_FOLLOWER;
      voted_q     <= 1'b0;
      voted_for_q <= '0;
      lead_vld_q  <= 1'b0;
      lead_idx_q  <= '0;
      cnt_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        term_q      <= term_d;
        role_q      <= role_d;
        voted_q     <= voted_d;
        voted_for_q <= voted_for_d;
        lead_vld_q  <= lead_vld_d;
        lead_idx_q  <= lead_idx_d;
        cnt_q       <= cnt_d;
        mask_q      <= mask_d;
      end
    end
  end

  logic [2:0]       kind_q;
  logic [TermW-1:0] o_term_q, o_idx_q, o_lt_q;
  logic             o_gr_q;
  logic [IdW-1:0]   o_sender_q;
  logic [1:0]       timer_q;
  logic [1:0]       o_role_q;
  logic             o_known_q;
  logic [IdW-1:0]   o_leader_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q     <= kind_d;
      o_term_q   <= o_term_d;
      o_gr_q     <= o_gr_d;
      o_idx_q    <= o_idx_d;
      o_lt_q     <= o_lt_d;
      o_sender_q <= node_id_q;
      timer_q    <= timer_d;
      o_role_q   <= role_d;
      o_known_q  <= lead_vld_d;
      o_leader_q <= lead_vld_d ? lead_idx_d : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign out_term_o     = o_term_q;
  assign out_granted_o  = o_gr_q;
  assign out_index_o    = o_idx_q;
  assign out_log_term_o = o_lt_q;
  assign out_sender_o   = o_sender_q;
  assign timer_action_o = timer_q;
  assign role_now_o     = o_role_q;
  assign leader_known_o = o_known_q;
  assign leader_now_o   = o_leader_q;

endmodule

FILE: src/raft_chk.sv
`timescale 1ns / 1ps
`include "raft_election_state_machine_top_defines.svh"

// Port-level checks on the result channel of the election core.
module raft_chk
  import raft_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       out_kind_o,
  input logic [TermW-1:0] out_term_o,
  input logic             out_granted_o,
  input logic [IdW-1:0]   out_sender_o,
  input logic [1:0]       timer_action_o,
  input logic [1:0]       role_now_o,
  input logic             leader_known_o,
  input logic [IdW-1:0]   leader_now_o
);

  // no result offered on the edge after reset is seen low
  `RAFT_ASSERT_RST(a_rst_idle, !rst_ni |=> !out_valid_o, "result valid during reset")

  // a stalled result stays and keeps its contents
  `RAFT_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o) && $stable(out_term_o), "stalled result changed")

  // a leader always has a leader recorded
  `RAFT_ASSERT(a_leader_known, out_valid_o && role_now_o == ROLE_LEADER |-> leader_known_o, "leader without recorded leader")

  // an empty result carries no term and no verdict
  `RAFT_ASSERT(a_none_clean, out_valid_o && out_kind_o == KIND_NONE |-> out_term_o == '0 && !out_granted_o, "empty result carries data")

  // a vote request goes out only as candidate and restarts the election timer
  `RAFT_ASSERT(a_vote_req, out_valid_o && out_kind_o == KIND_BCAST_VOTE |-> role_now_o == ROLE_CANDIDATE && timer_action_o == TMR_RESTART, "vote request outside candidacy")

endmodule

bind raft_election_state_machine_top raft_chk u_raft_chk (.*);

FILE: bench/tb_raft_election_state_machine_top.sv
`timescale 1ns / 1ps

module tb_raft_election_state_machine_top;
  import raft_pkg::*;

  localparam int          CycleLimit     = 200000;
  localparam int          PhaseItems     = 144;
  localparam int          NumPhases      = 8;
  localparam logic [2:0]  CmdFirstUnused = 3'd5;
  localparam logic [63:0] TermMax        = '1;

  // one event item
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] term;
    logic [3:0]  sender;
    logic        granted;
    logic [63:0] c_idx;
    logic [63:0] c_term;
  } evt_t;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] term;
    logic        granted;
    logic [63:0] index;
    logic [63:0] log_term;
    logic [3:0]  sender;
    logic [1:0]  timer;
    logic [1:0]  role;
    logic        lk;
    logic [3:0]  ln;
  } rsp_t;

  // election state of the node
  typedef struct packed {
    logic [63:0] term;
    logic [1:0]  role;
    logic        voted;
    logic [3:0]  voted_for;
    logic        ldr_valid;
    logic [3:0]  ldr;
    logic [4:0]  votes;
    logic [15:0] voters;
  } node_st_t;

  typedef struct packed {
    logic [3:0]  node_id;
    logic [3:0]  num_peers;
    logic [63:0] last_idx;
    logic [63:0] last_term;
  } cfg_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic [1:0]  cfg_idx_i         = '0;
  logic [63:0] cfg_wdata_i       = '0;
  logic        in_valid_i        = 1'b0;
  logic [2:0]  cmd_i             = '0;
  logic [63:0] msg_term_i        = '0;
  logic [3:0]  sender_id_i       = '0;
  logic        vote_granted_i    = 1'b0;
  logic [63:0] cand_last_index_i = '0;
  logic [63:0] cand_last_term_i  = '0;
  logic        out_stall_i       = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  out_kind_o;
  logic [63:0] out_term_o;
  logic        out_granted_o;
  logic [63:0] out_index_o;
  logic [63:0] out_log_term_o;
  logic [3:0]  out_sender_o;
  logic [1:0]  timer_action_o;
  logic [1:0]  role_now_o;
  logic        leader_known_o;
  logic [3:0]  leader_now_o;

  raft_election_state_machine_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .msg_term_i       (msg_term_i),
    .sender_id_i      (sender_id_i),
    .vote_granted_i   (vote_granted_i),
    .cand_last_index_i(cand_last_index_i),
    .cand_last_term_i (cand_last_term_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .out_term_o       (out_term_o),
    .out_granted_o    (out_granted_o),
    .out_index_o      (out_index_o),
    .out_log_term_o   (out_log_term_o),
    .out_sender_o     (out_sender_o),
    .timer_action_o   (timer_action_o),
    .role_now_o       (role_now_o),
    .leader_known_o   (leader_known_o),
    .leader_now_o     (leader_now_o)
  );

  node_st_t node_live = '0;   // advanced at each accepted item
  node_st_t node_plan = '0;   // advanced as items are generated
  cfg_t     cfg       = '0;
  evt_t     event_q[$];
  rsp_t     reply_q[$];
  evt_t     drv_evt   = '0;
  evt_t     next_evt;
  rsp_t     want_rsp;
  rsp_t     pred_rsp;
  logic     evt_taken = 1'b0;
  int       err_cnt   = 0;
  int       n_taken   = 0;
  int       gen_cnt   = 0;
  int       cycles    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void step_down(inout node_st_t s, input logic [63:0] t);
    s      = '0;
    s.term = t;
  endfunction

  function automatic void fill_bcast(inout rsp_t r, input logic [63:0] t, input cfg_t c);
    r.term     = t;
    r.index    = c.last_idx;
    r.log_term = c.last_term;
  endfunction

  // Election step: updates the node state and returns the single result
  function automatic void step_node(inout node_st_t s, input cfg_t c, input evt_t e,
                                    output rsp_t r);
    logic grant;
    logic stepped;
    logic was_other;
    logic log_ok;
    r     = '0;
    grant = 1'b0;
    case (e.cmd)
      CMD_TIMEOUT: begin
        if (s.role != ROLE_LEADER) begin
          s.term      = s.term + 64'd1;
          s.role      = ROLE_CANDIDATE;
          s.voted     = 1'b1;
          s.voted_for = c.node_id;
          s.votes     = 5'd1;
          s.voters    = 16'd1 << c.node_id;
          s.ldr_valid = 1'b0;
          s.ldr       = '0;
          // single-node cluster wins at once
          if (c.num_peers == 4'd0) begin
            s.role      = ROLE_LEADER;
            s.ldr_valid = 1'b1;
            s.ldr       = c.node_id;
            r.timer     = TMR_HEARTBEAT;
            r.kind      = KIND_BCAST_HB;
          end else begin
            r.timer = TMR_RESTART;
            r.kind  = KIND_BCAST_VOTE;
          end
          fill_bcast(r, s.term, c);
        end
      end
      CMD_TICK: begin
        if (s.role == ROLE_LEADER) begin
          r.kind = KIND_BCAST_HB;
          fill_bcast(r, s.term, c);
        end
      end
      CMD_VOTE_RSP: begin
        if (e.term > s.term) begin
          step_down(s, e.term);
          r.timer = TMR_ELECTION;
        end else if (e.term == s.term && s.role == ROLE_CANDIDATE && e.granted &&
                     !s.voters[e.sender]) begin
          s.voters[e.sender] = 1'b1;
          s.votes            = s.votes + 5'd1;
          // strict majority of peers plus self
          if (int'(s.votes) > (int'(c.num_peers) + 1) / 2) begin
            s.role      = ROLE_LEADER;
            s.ldr_valid = 1'b1;
            s.ldr       = c.node_id;
            r.timer     = TMR_HEARTBEAT;
            r.kind      = KIND_BCAST_HB;
            fill_bcast(r, s.term, c);
          end
        end
      end
      CMD_REQ_VOTE: begin
        r.kind = KIND_VOTE_REPLY;
        if (e.term >= s.term) begin
          stepped = e.term > s.term;
          if (stepped) step_down(s, e.term);
          log_ok = (e.c_term > c.last_term) ||
                   (e.c_term == c.last_term && e.c_idx >= c.last_idx);
          if (log_ok && !(s.voted && s.voted_for != e.sender)) begin
            s.voted     = 1'b1;
            s.voted_for = e.sender;
            grant       = 1'b1;
          end
          r.timer = stepped ? TMR_ELECTION : (grant ? TMR_RESTART : TMR_NONE);
        end
        r.term    = s.term;
        r.granted = grant;
      end
      CMD_APPEND: begin
        r.kind = KIND_APPEND_REPLY;
        if (e.term >= s.term) begin
          was_other = s.role != ROLE_FOLLOWER;
          if (e.term > s.term) begin
            step_down(s, e.term);
          end else if (s.role != ROLE_FOLLOWER) begin
            s.role   = ROLE_FOLLOWER;
            s.votes  = '0;
            s.voters = '0;
          end
          // a different leader already recorded in this term: reject
          if (!s.ldr_valid) begin
            s.ldr_valid = 1'b1;
            s.ldr       = e.sender;
            grant       = 1'b1;
          end else begin
            grant = s.ldr == e.sender;
          end
          r.timer = was_other ? TMR_ELECTION : (grant ? TMR_RESTART : TMR_NONE);
        end
        r.term    = s.term;
        r.granted = grant;
        r.index   = c.last_idx;
      end
      default: ;
    endcase
    r.sender = c.node_id;
    r.role   = s.role;
    r.lk     = s.ldr_valid;
    r.ln     = s.ldr_valid ? s.ldr : 4'd0;
  endfunction

  function automatic evt_t new_evt(input logic [2:0] cmd, input logic [63:0] t,
                                   input logic [3:0] sender, input logic g);
    evt_t e;
    e.cmd     = cmd;
    e.term    = t;
    e.sender  = sender;
    e.granted = g;
    e.c_idx   = rand64();
    e.c_term  = rand64();
    return e;
  endfunction

  // message term around the node's current term, with wild values now and then
  function automatic logic [63:0] pick_term(input logic [63:0] t);
    case ($urandom_range(7))
      0, 1, 2: return t;
      3:       return t + 64'd1;
      4:       return t - 64'd1;
      5:       return t + 64'($urandom_range(2, 5));
      6:       return rand64();
      default: return ($urandom_range(1) != 0) ? TermMax : 64'd0;
    endcase
  endfunction

  function automatic logic [63:0] pick_log(input logic [63:0] v);
    case ($urandom_range(4))
      0, 1:    return v;
      2:       return v + 64'd1;
      3:       return v - 64'd1;
      default: return rand64();
    endcase
  endfunction

  task automatic report_err(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_fld(input string name, input logic [63:0] w, input logic [63:0] g);
    if (g !== w) report_err($sformatf("%s expected %0h got %0h", name, w, g));
  endtask

  task automatic push_evt(input evt_t e);
    rsp_t unused;
    event_q.push_back(e);
    step_node(node_plan, cfg, e, unused);
    gen_cnt++;
  endtask

  // one well-formed exchange, or a stray item
  task automatic gen_episode();
    int   sel;
    int   n;
    evt_t e;
    sel = $urandom_range(99);
    if (sel < 35) begin
      // election: timeout, then votes, mostly in the new term, then ticks
      push_evt(new_evt(CMD_TIMEOUT, rand64(), 4'($urandom), 1'($urandom)));
      n = $urandom_range(1, int'(cfg.num_peers) + 2);
      repeat (n) begin
        e = new_evt(CMD_VOTE_RSP,
                    ($urandom_range(9) == 0) ? pick_term(node_plan.term) : node_plan.term,
                    4'($urandom), $urandom_range(99) < 85);
        push_evt(e);
      end
      repeat ($urandom_range(2))
        push_evt(new_evt(CMD_TICK, rand64(), 4'($urandom), 1'($urandom)));
    end else if (sel < 50) begin
      e = new_evt(CMD_REQ_VOTE, pick_term(node_plan.term),
                  ($urandom_range(3) == 0) ? node_plan.voted_for : 4'($urandom),
                  1'($urandom));
      e.c_term = pick_log(cfg.last_term);
      e.c_idx  = pick_log(cfg.last_idx);
      push_evt(e);
    end else if (sel < 70) begin
      e = new_evt(CMD_APPEND,
                  ($urandom_range(3) == 0) ? node_plan.term + 64'd1 :
                  ($urandom_range(5) == 0) ? pick_term(node_plan.term) : node_plan.term,
                  (node_plan.ldr_valid && $urandom_range(1) != 0) ?
                  node_plan.ldr : 4'($urandom),
                  1'($urandom));
      push_evt(e);
    end else if (sel < 80) begin
      push_evt(new_evt(CMD_TICK, rand64(), 4'($urandom), 1'($urandom)));
    end else if (sel < 88) begin
      push_evt(new_evt(CMD_TIMEOUT, rand64(), 4'($urandom), 1'($urandom)));
    end else begin
      push_evt(new_evt(3'($urandom_range(7)), rand64(), 4'($urandom), 1'($urandom)));
    end
  endtask

  task automatic write_reg(input reg_e idx, input logic [63:0] d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    case (idx)
      REG_NODE_ID:   cfg.node_id   = d[3:0];
      REG_NUM_PEERS: cfg.num_peers = d[3:0];
      REG_LAST_IDX:  cfg.last_idx  = d;
      REG_LAST_TERM: cfg.last_term = d;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_cfg(input logic [3:0] node, input logic [3:0] peers,
                         input logic [63:0] l_idx, input logic [63:0] l_term);
    logic [63:0] d;
    // junk in the unused upper bits of the narrow registers
    d      = rand64();
    d[3:0] = node;
    write_reg(REG_NODE_ID, d);
    d      = rand64();
    d[3:0] = peers;
    write_reg(REG_NUM_PEERS, d);
    write_reg(REG_LAST_IDX, l_idx);
    write_reg(REG_LAST_TERM, l_term);
    node_plan = node_live;
  endtask

  // wait until every item is taken and answered, then let the pipeline settle
  task automatic drain();
    while (event_q.size() != 0 || in_valid_i || reply_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic add_vote_rsp(input logic [63:0] t, input logic [3:0] sender,
                              input logic g);
    push_evt(new_evt(CMD_VOTE_RSP, t, sender, g));
  endtask

  task automatic add_req_vote(input logic [63:0] t, input logic [3:0] sender,
                              input logic [63:0] c_term, input logic [63:0] c_idx);
    evt_t e;
    e        = new_evt(CMD_REQ_VOTE, t, sender, 1'($urandom));
    e.c_term = c_term;
    e.c_idx  = c_idx;
    push_evt(e);
  endtask

  // sender side: next item at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || evt_taken) begin
        if (event_q.size() != 0 &&
            $urandom_range(99) >= ((n_taken < 400) ? 12 : (n_taken < 800) ? 50 : 0)) begin
          next_evt          = event_q.pop_front();
          drv_evt           <= next_evt;
          cmd_i             <= next_evt.cmd;
          msg_term_i        <= next_evt.term;
          sender_id_i       <= next_evt.sender;
          vote_granted_i    <= next_evt.granted;
          cand_last_index_i <= next_evt.c_idx;
          cand_last_term_i  <= next_evt.c_term;
          in_valid_i        <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= $urandom_range(99) < ((n_taken < 400) ? 50 : (n_taken < 800) ? 12 : 0);
    end
  end

  // check results and predict for taken items at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report_err("result with no event pending");
        end else begin
          want_rsp = reply_q.pop_front();
          check_fld("out_kind", want_rsp.kind, out_kind_o);
          check_fld("out_term", want_rsp.term, out_term_o);
          check_fld("out_granted", want_rsp.granted, out_granted_o);
          check_fld("out_index", want_rsp.index, out_index_o);
          check_fld("out_log_term", want_rsp.log_term, out_log_term_o);
          check_fld("out_sender", want_rsp.sender, out_sender_o);
          check_fld("timer_action", want_rsp.timer, timer_action_o);
          check_fld("role_now", want_rsp.role, role_now_o);
          check_fld("leader_known", want_rsp.lk, leader_known_o);
          check_fld("leader_now", want_rsp.ln, leader_now_o);
        end
      end
      evt_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        step_node(node_live, cfg, drv_evt, pred_rsp);
        reply_q.push_back(pred_rsp);
        n_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: node 5 in a five-node cluster, log at (term 3, index 10)
    set_cfg(4'd5, 4'd4, 64'd10, 64'd3);
    push_evt(new_evt(CMD_TICK, 64'd0, 4'd0, 1'b0));       // tick as follower
    add_vote_rsp(64'd0, 4'd1, 1'b1);                      // vote while follower
    add_req_vote(64'd0, 4'd7, 64'd2, 64'd100);            // older log: refuse
    add_req_vote(64'd0, 4'd7, 64'd3, 64'd10);             // equal log: grant
    add_req_vote(64'd0, 4'd8, 64'd4, 64'd0);              // already voted
    push_evt(new_evt(CMD_TIMEOUT, 64'd0, 4'd0, 1'b0));    // become candidate
    add_vote_rsp(64'd1, 4'd1, 1'b0);                      // vote refused
    add_vote_rsp(64'd1, 4'd1, 1'b1);
    add_vote_rsp(64'd1, 4'd1, 1'b1);                      // same voter twice
    add_vote_rsp(64'd1, 4'd5, 1'b1);                      // own id again
    add_vote_rsp(64'd1, 4'd2, 1'b1);                      // majority: leader
    push_evt(new_evt(CMD_TIMEOUT, 64'd0, 4'd0, 1'b0));    // timeout as leader
    push_evt(new_evt(CMD_TICK, 64'd0, 4'd0, 1'b0));       // heartbeat
    push_evt(new_evt(CMD_APPEND, 64'd1, 4'd9, 1'b0));     // other leader, same term
    push_evt(new_evt(CMD_APPEND, 64'd1, 4'd9, 1'b0));
    push_evt(new_evt(CMD_APPEND, 64'd2, 4'd9, 1'b0));     // newer term: accept
    add_vote_rsp(64'd5, 4'd3, 1'b0);                      // higher term response
    add_vote_rsp(64'd3, 4'd3, 1'b1);                      // stale response
    add_req_vote(64'd6, 4'd3, TermMax, 64'd0);
    push_evt(new_evt(CMD_APPEND, TermMax, 4'd15, 1'b1));  // term at its maximum
    push_evt(new_evt(CMD_TIMEOUT, 64'd0, 4'd0, 1'b0));    // term wraps to zero
    for (int k = 0; k < 3; k++)
      push_evt(new_evt(CmdFirstUnused + 3'(k), rand64(), 4'($urandom), 1'($urandom)));
    add_req_vote(64'd0, 4'd0, TermMax, TermMax);
    push_evt(new_evt(CMD_APPEND, 64'd0, 4'd0, 1'b1));     // candidate steps back
    drain();

    // random phases, each under its own configuration
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_cfg(4'd0, 4'd0, 64'd0, 64'd0);
        1: set_cfg(4'd15, 4'd15, TermMax, TermMax);
        default: set_cfg(4'($urandom),
                         ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 6)),
                         ($urandom_range(1) != 0) ? rand64() : 64'($urandom_range(20)),
                         ($urandom_range(1) != 0) ? rand64() : 64'($urandom_range(20)));
      endcase
      gen_cnt = 0;
      while (gen_cnt < PhaseItems) gen_episode();
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
